// ===== rtl/pccs_pkg.sv =====
// ----------------------------------------------------------------------------
// pccs_pkg
// Shared types and constants for the point cloud cluster statistics block.
// ----------------------------------------------------------------------------
package pccs_pkg;

    localparam int CW        = 24;
    localparam int TOTAL_W   = 15;
    localparam int SUM_W     = 48;
    localparam int SQ_W      = 64;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic                 last;
    } point_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]   particle_total;
        logic signed [CW-1:0] mass_center_x;
        logic signed [CW-1:0] mass_center_y;
        logic [CW-1:0]        gyration_radius;
        logic [CW-1:0]        largest_radius;
        logic signed [CW-1:0] box_min_x;
        logic signed [CW-1:0] box_min_y;
        logic signed [CW-1:0] box_max_x;
        logic signed [CW-1:0] box_max_y;
        logic                 overflow;
    } stats_t;

    // queue entry from front to back: point plus decision whether it is stored
    typedef struct packed {
        point_t pt;
        logic   keep;
    } qent_t;

endpackage

// ===== rtl/pccs_stream_if.sv =====
// ----------------------------------------------------------------------------
// pccs_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface pccs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/pccs_ram.sv =====
// ----------------------------------------------------------------------------
// pccs_ram
// Single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pccs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/pccs_front.sv =====
// ----------------------------------------------------------------------------
// pccs_front
// Accepts points, decides which ones fit in the buffer, feeds a short queue.
// ----------------------------------------------------------------------------
module pccs_front #(
    parameter int MAX_POINTS = 16384,
    parameter int QDEPTH     = 4
) (
    input  logic clk,
    input  logic rst_n,
    pccs_stream_if.sink in_ch,
    output pccs_pkg::qent_t q_data,
    output logic            q_valid,
    input  logic            q_pop
);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int QAW  = $clog2(QDEPTH);

    pccs_pkg::qent_t  q_mem [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     fill_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             push;

    assign in_ch.ready = (fill_reg != (QAW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (fill_reg != '0);
    assign q_data      = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg].pt   <= in_ch.payload;
            q_mem[wp_reg].keep <= (cnt_reg != CNTW'(MAX_POINTS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == QAW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
                if (in_ch.payload.last)
                begin
                    cnt_reg <= '0;
                end
                else if (cnt_reg != CNTW'(MAX_POINTS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == QAW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
        end
    end
endmodule

// ===== rtl/pccs_back.sv =====
// ----------------------------------------------------------------------------
// pccs_back
// Accumulates the run, then divides, runs the second pass and square roots.
// ----------------------------------------------------------------------------
module pccs_back #(
    parameter int MAX_POINTS = 16384
) (
    input  logic clk,
    input  logic rst_n,
    input  pccs_pkg::qent_t q_data,
    input  logic            q_valid,
    output logic            q_pop,
    pccs_stream_if.source out_ch
);
    localparam int CW   = pccs_pkg::CW;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SW   = pccs_pkg::SUM_W;
    localparam int QW   = pccs_pkg::SQ_W;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [7:0] {
        S_ACC   = 8'b0000_0001,
        S_DIVC  = 8'b0000_0010,
        S_PASS  = 8'b0000_0100,
        S_DIVG  = 8'b0000_1000,
        S_SQG   = 8'b0001_0000,
        S_SQR   = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_DRAIN = 8'b1000_0000
    } st_t;

    st_t                  st_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [CW-1:0] mnx_reg, mny_reg, mxx_reg, mxy_reg;
    logic [QW-1:0]        peak_reg;
    logic                 ovf_reg;
    logic [6:0]           step_reg;

    // shared restoring divider / square root, one bit per cycle
    logic [QW-1:0] num_reg, quo_reg, rem_reg;
    logic [1:0]    dsel_reg;           // 0: cx, 1: cy, 2: gyration
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [QW-1:0] acc_reg;
    logic [CW-1:0] g_reg, r_reg;
    logic [QW-1:0] sq_v_reg, sq_res_reg, sq_bit_reg;

    // second pass
    logic [AW-1:0]        raddr_reg;
    logic [CNTW-1:0]      ridx_reg;
    logic                 rv_reg, rv2_reg, rv3_reg;
    logic [CW-1:0]        rx, ry;
    logic [QW-1:0]        dsq_reg;
    logic [2*CW-1:0]      mx_reg, my_reg;

    pccs_pkg::stats_t res_reg;
    logic             oval_reg;

    logic wr;
    assign q_pop = q_valid && (st_reg == S_ACC);
    assign wr    = q_pop && q_data.keep;

    pccs_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_xram (
        .clk(clk), .we(wr), .waddr(cnt_reg[AW-1:0]), .wdata(q_data.pt.pos_x),
        .raddr(raddr_reg), .rdata(rx));
    pccs_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_yram (
        .clk(clk), .we(wr), .waddr(cnt_reg[AW-1:0]), .wdata(q_data.pt.pos_y),
        .raddr(raddr_reg), .rdata(ry));

    logic [CW-1:0]   ax, ay;
    logic [2*CW-1:0] r2x, r2y;
    logic [2*CW:0]   r2;
    assign ax  = q_data.pt.pos_x[CW-1] ? CW'(-q_data.pt.pos_x) : q_data.pt.pos_x;
    assign ay  = q_data.pt.pos_y[CW-1] ? CW'(-q_data.pt.pos_y) : q_data.pt.pos_y;
    assign r2x = ax * ax;
    assign r2y = ay * ay;
    assign r2  = {1'b0, r2x} + {1'b0, r2y};

    // second pass differences
    logic signed [CW:0] dx, dy;
    logic [CW:0]        adx, ady;
    logic [2*CW+2:0]    dsum;
    logic [QW:0]        accn;
    assign dx   = $signed({rx[CW-1], rx}) - $signed({cx_reg[CW-1], cx_reg});
    assign dy   = $signed({ry[CW-1], ry}) - $signed({cy_reg[CW-1], cy_reg});
    assign adx  = dx[CW] ? (CW+1)'(-dx) : dx;
    assign ady  = dy[CW] ? (CW+1)'(-dy) : dy;
    assign dsum = (2*CW+3)'(mx_reg) + (2*CW+3)'(my_reg);
    assign accn = {1'b0, acc_reg} + {1'b0, dsq_reg};

    // divider step
    logic [QW:0]   rsh;
    logic [QW:0]   dvs;
    assign rsh = {rem_reg, num_reg[QW-1]};
    assign dvs = (QW+1)'(cnt_reg);

    // sqrt step
    logic [QW:0] sq_t;
    assign sq_t = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};

    logic [QW-1:0] sq_seed;
    assign sq_seed = {2'b01, {(QW-2){1'b0}}};

    // x sum including the item being popped, so the last item counts
    logic signed [SW-1:0] sx_next;
    assign sx_next = q_data.keep ? sx_reg + SW'(q_data.pt.pos_x) : sx_reg;

    logic div_neg_reg;
    logic [SW-1:0] sx_mag, sy_mag;
    assign sx_mag = sx_next[SW-1] ? SW'(-sx_next) : sx_next;
    assign sy_mag = sy_reg[SW-1] ? SW'(-sy_reg) : sy_reg;

    assign out_ch.valid   = oval_reg;
    assign out_ch.payload = res_reg;

    always_ff @(posedge clk)
    begin
        mx_reg  <= adx * adx;
        my_reg  <= ady * ady;
        dsq_reg <= QW'(dsum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_ACC;
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            mnx_reg  <= CMAX;
            mny_reg  <= CMAX;
            mxx_reg  <= CMIN;
            mxy_reg  <= CMIN;
            peak_reg <= '0;
            ovf_reg  <= 1'b0;
            oval_reg <= 1'b0;
            step_reg <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsel_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            acc_reg  <= '0;
            g_reg    <= '0;
            r_reg    <= '0;
            sq_v_reg <= '0;
            sq_res_reg <= '0;
            sq_bit_reg <= '0;
            raddr_reg  <= '0;
            ridx_reg   <= '0;
            rv_reg     <= 1'b0;
            rv2_reg    <= 1'b0;
            rv3_reg    <= 1'b0;
            div_neg_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
            case (st_reg)
                S_ACC:
                begin
                    if (q_pop)
                    begin
                        if (q_data.keep)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            sx_reg  <= sx_next;
                            sy_reg  <= sy_reg + SW'(q_data.pt.pos_y);
                            if (q_data.pt.pos_x < mnx_reg) mnx_reg <= q_data.pt.pos_x;
                            if (q_data.pt.pos_y < mny_reg) mny_reg <= q_data.pt.pos_y;
                            if (q_data.pt.pos_x > mxx_reg) mxx_reg <= q_data.pt.pos_x;
                            if (q_data.pt.pos_y > mxy_reg) mxy_reg <= q_data.pt.pos_y;
                            if (QW'(r2) > peak_reg) peak_reg <= QW'(r2);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (q_data.pt.last)
                        begin
                            st_reg   <= S_DIVC;
                            dsel_reg <= 2'd0;
                            step_reg <= '0;
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            num_reg  <= QW'(sx_mag);
                            div_neg_reg <= sx_next[SW-1];
                        end
                    end
                end
                S_DIVC, S_DIVG:
                begin
                    // restoring division of num_reg by cnt_reg (cnt is never zero)
                    num_reg <= num_reg << 1;
                    if (rsh >= dvs)
                    begin
                        rem_reg <= QW'(rsh - dvs);
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= QW'(rsh);
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'(QW))
                    begin
                        step_reg <= '0;
                        rem_reg  <= '0;
                        num_reg  <= QW'(sy_mag);
                        if (dsel_reg == 2'd0)
                        begin
                            cx_reg      <= div_neg_reg ? CW'(-quo_reg) : CW'(quo_reg);
                            div_neg_reg <= sy_reg[SW-1];
                            dsel_reg    <= 2'd1;
                        end
                        else if (dsel_reg == 2'd1)
                        begin
                            cy_reg    <= div_neg_reg ? CW'(-quo_reg) : CW'(quo_reg);
                            st_reg    <= S_PASS;
                            raddr_reg <= '0;
                            ridx_reg  <= '0;
                            acc_reg   <= '0;
                            rv_reg    <= 1'b0;
                            rv2_reg   <= 1'b0;
                            rv3_reg   <= 1'b0;
                        end
                        else
                        begin
                            st_reg     <= S_SQG;
                            sq_v_reg   <= quo_reg;
                            sq_res_reg <= '0;
                            sq_bit_reg <= sq_seed;
                        end
                    end
                end
                S_PASS:
                begin
                    // read, square, add, accumulate: four stage pipe per entry
                    rv_reg  <= (ridx_reg != cnt_reg);
                    rv2_reg <= rv_reg;
                    rv3_reg <= rv2_reg;
                    if (ridx_reg != cnt_reg)
                    begin
                        ridx_reg  <= ridx_reg + 1'b1;
                        raddr_reg <= raddr_reg + 1'b1;
                    end
                    if (rv3_reg)
                    begin
                        acc_reg <= accn[QW] ? {QW{1'b1}} : accn[QW-1:0];
                    end
                    if (ridx_reg == cnt_reg && !rv_reg && !rv2_reg && !rv3_reg
                        && step_reg == 7'd3)
                    begin
                        st_reg   <= S_DIVG;
                        dsel_reg <= 2'd2;
                        step_reg <= '0;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        num_reg  <= acc_reg;
                    end
                    else if (ridx_reg == cnt_reg)
                    begin
                        step_reg <= (step_reg == 7'd3) ? step_reg : step_reg + 1'b1;
                    end
                end
                S_SQG, S_SQR:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        if (st_reg == S_SQG)
                        begin
                            g_reg      <= (sq_res_reg > QW'({CW{1'b1}})) ? {CW{1'b1}}
                                                                        : CW'(sq_res_reg);
                            st_reg     <= S_SQR;
                            sq_v_reg   <= peak_reg;
                            sq_res_reg <= '0;
                            sq_bit_reg <= sq_seed;
                        end
                        else
                        begin
                            r_reg  <= (sq_res_reg > QW'({CW{1'b1}})) ? {CW{1'b1}}
                                                                    : CW'(sq_res_reg);
                            st_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        if ({1'b0, sq_v_reg} >= sq_t)
                        begin
                            sq_v_reg   <= QW'({1'b0, sq_v_reg} - sq_t);
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                S_OUT:
                begin
                    if (!oval_reg)
                    begin
                        oval_reg <= 1'b1;
                        res_reg.particle_total  <= pccs_pkg::TOTAL_W'(cnt_reg);
                        res_reg.mass_center_x   <= cx_reg;
                        res_reg.mass_center_y   <= cy_reg;
                        res_reg.gyration_radius <= g_reg;
                        res_reg.largest_radius  <= r_reg;
                        res_reg.box_min_x       <= mnx_reg;
                        res_reg.box_min_y       <= mny_reg;
                        res_reg.box_max_x       <= mxx_reg;
                        res_reg.box_max_y       <= mxy_reg;
                        res_reg.overflow        <= ovf_reg;
                        st_reg   <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    cnt_reg  <= '0;
                    sx_reg   <= '0;
                    sy_reg   <= '0;
                    mnx_reg  <= CMAX;
                    mny_reg  <= CMAX;
                    mxx_reg  <= CMIN;
                    mxy_reg  <= CMIN;
                    peak_reg <= '0;
                    ovf_reg  <= 1'b0;
                    step_reg <= '0;
                    st_reg   <= S_ACC;
                end
                default:
                begin
                    st_reg <= S_ACC;
                end
            endcase
        end
    end
endmodule

// ===== rtl/point_cloud_cluster_statistics_top.sv =====
// ----------------------------------------------------------------------------
// point_cloud_cluster_statistics_top
// Cluster statistics over a run of 2D fixed point particles.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one particle per item (pos_x, pos_y, last). out_ch carries
//   one statistics item per run, after the item flagged last.
//   Particles are taken one per cycle while the queue has room; a small
//   queue decouples the input from the accumulator. After the last item the
//   block runs two divides for the center, a second pass over the buffer, a
//   divide and two square roots. Input keeps flowing into the queue until it
//   is full during that time.
//   Reset clears all run state; buffer contents need no clearing.
//   A stalled result holds in the output register until taken; the next
//   run's items are accumulated meanwhile.
// ----------------------------------------------------------------------------
module point_cloud_cluster_statistics_top #(
    parameter int MAX_POINTS = 16384
) (
    input  logic clk,
    input  logic rst_n,
    pccs_stream_if.sink   in_ch,
    pccs_stream_if.source out_ch
);
    pccs_pkg::qent_t q_data;
    logic            q_valid;
    logic            q_pop;

    pccs_front #(.MAX_POINTS(MAX_POINTS), .QDEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));

    pccs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch));

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped while stalled");
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.payload.particle_total <= 15'(MAX_POINTS))
        else $error("count beyond buffer depth");
endmodule

// ===== tb/sv/tb_point_cloud_cluster_statistics_top.sv =====
// ----------------------------------------------------------------------------
// tb_point_cloud_cluster_statistics_top
// Self-checking bench for the cluster statistics block: runs of particles go
// in with random gaps, a built-in predictor works out each run's statistics,
// and every result item is checked field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_point_cloud_cluster_statistics_top;

    localparam int CW        = pccs_pkg::CW;
    localparam int DEPTH     = 16384;
    localparam int CYC_LIMIT = 1000000;
    localparam int HOLD_AT   = 1200;
    localparam int HOLD_LEN  = 3000;
    localparam int QUIET_LO  = 6000;
    localparam int QUIET_HI  = 9000;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        pccs_pkg::point_t pt;
        bit               drain_first; // hold this item until all results are in
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pccs_stream_if #(.T(pccs_pkg::point_t)) in_ch ();
    pccs_stream_if #(.T(pccs_pkg::stats_t)) out_ch ();

    point_cloud_cluster_statistics_top #(.MAX_POINTS(DEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    stim_t            pending_pts[$];
    pccs_pkg::stats_t stats_due[$];
    int     errors = 0;
    int     cycle = 0;
    int     hold_left = 0;

    // predictor run state
    int                   run_cnt;
    longint               run_sx, run_sy;
    longint               bmin_x, bmin_y, bmax_x, bmax_y;
    longint unsigned      peak_sq;
    bit                   run_ovf;
    longint               run_xs[$], run_ys[$];

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v && trial <= 64'hFFFF_FFFF)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned clip24(longint unsigned v);
        return (v > 64'hFF_FFFF) ? 64'hFF_FFFF : v;
    endfunction

    task automatic clear_run_state();
        run_cnt = 0;
        run_sx  = 0;
        run_sy  = 0;
        bmin_x  = C_MAX;
        bmin_y  = C_MAX;
        bmax_x  = C_MIN;
        bmax_y  = C_MIN;
        peak_sq = 0;
        run_ovf = 1'b0;
        run_xs.delete();
        run_ys.delete();
    endtask

    task automatic track_point(pccs_pkg::point_t p);
        longint           x, y, cx, cy;
        longint unsigned  r2, acc, dx, dy;
        pccs_pkg::stats_t s;
        x = $signed(p.pos_x);
        y = $signed(p.pos_y);
        if (run_cnt < DEPTH)
        begin
            run_xs.insert(run_xs.size(), x);
            run_ys.insert(run_ys.size(), y);
            run_cnt++;
            run_sx += x;
            run_sy += y;
            if (x < bmin_x) bmin_x = x;
            if (y < bmin_y) bmin_y = y;
            if (x > bmax_x) bmax_x = x;
            if (y > bmax_y) bmax_y = y;
            r2 = longint'(x * x) + longint'(y * y);
            if (r2 > peak_sq) peak_sq = r2;
        end
        else
            run_ovf = 1'b1;
        if (!p.last)
            return;
        s = '0;
        s.overflow = run_ovf;
        if (run_cnt != 0)
        begin
            cx  = run_sx / run_cnt; // truncates toward zero
            cy  = run_sy / run_cnt;
            acc = 0;
            for (int i = 0; i < run_cnt; i++)
            begin
                dx  = (run_xs[i] - cx) < 0 ? cx - run_xs[i] : run_xs[i] - cx;
                dy  = (run_ys[i] - cy) < 0 ? cy - run_ys[i] : run_ys[i] - cy;
                acc = sat_sum(acc, sat_sum(dx * dx, dy * dy));
            end
            s.particle_total  = pccs_pkg::TOTAL_W'(run_cnt);
            s.mass_center_x   = CW'(cx);
            s.mass_center_y   = CW'(cy);
            s.gyration_radius = CW'(clip24(int_sqrt(acc / longint'(run_cnt))));
            s.largest_radius  = CW'(clip24(int_sqrt(peak_sq)));
            s.box_min_x       = CW'(bmin_x);
            s.box_min_y       = CW'(bmin_y);
            s.box_max_x       = CW'(bmax_x);
            s.box_max_y       = CW'(bmax_y);
        end
        stats_due.insert(stats_due.size(), s);
        clear_run_state();
    endtask

    function automatic bit quiet_now();
        return cycle >= QUIET_LO && cycle < QUIET_HI;
    endfunction

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // particle driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                track_point(in_ch.payload);
            if (in_ch.valid && !in_ch.ready)
                ; // keep offering the same item
            else if (pending_pts.size() > 0
                     && !(pending_pts[0].drain_first && stats_due.size() > 0)
                     && (quiet_now() || $urandom_range(99) >= 16))
            begin
                stim_t nx;
                nx = pending_pts.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.payload <= nx.pt;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $error("result item with none expected");
                    errors++;
                end
                else
                begin
                    pccs_pkg::stats_t e, a;
                    e = stats_due.pop_front();
                    a = out_ch.payload;
                    if (a.particle_total !== e.particle_total)
                    begin
                        $error("particle_total exp %0d got %0d", e.particle_total,
                               a.particle_total);
                        errors++;
                    end
                    if (a.mass_center_x !== e.mass_center_x)
                    begin
                        $error("mass_center_x exp %0d got %0d", e.mass_center_x,
                               a.mass_center_x);
                        errors++;
                    end
                    if (a.mass_center_y !== e.mass_center_y)
                    begin
                        $error("mass_center_y exp %0d got %0d", e.mass_center_y,
                               a.mass_center_y);
                        errors++;
                    end
                    if (a.gyration_radius !== e.gyration_radius)
                    begin
                        $error("gyration_radius exp %0d got %0d", e.gyration_radius,
                               a.gyration_radius);
                        errors++;
                    end
                    if (a.largest_radius !== e.largest_radius)
                    begin
                        $error("largest_radius exp %0d got %0d", e.largest_radius,
                               a.largest_radius);
                        errors++;
                    end
                    if (a.box_min_x !== e.box_min_x)
                    begin
                        $error("box_min_x exp %0d got %0d", e.box_min_x, a.box_min_x);
                        errors++;
                    end
                    if (a.box_min_y !== e.box_min_y)
                    begin
                        $error("box_min_y exp %0d got %0d", e.box_min_y, a.box_min_y);
                        errors++;
                    end
                    if (a.box_max_x !== e.box_max_x)
                    begin
                        $error("box_max_x exp %0d got %0d", e.box_max_x, a.box_max_x);
                        errors++;
                    end
                    if (a.box_max_y !== e.box_max_y)
                    begin
                        $error("box_max_y exp %0d got %0d", e.box_max_y, a.box_max_y);
                        errors++;
                    end
                    if (a.overflow !== e.overflow)
                    begin
                        $error("overflow exp %0d got %0d", e.overflow, a.overflow);
                        errors++;
                    end
                end
            end
            // one long hold-off so the input queue fills and backs up
            if (cycle == HOLD_AT)
                hold_left <= HOLD_LEN;
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= (cycle != HOLD_AT)
                                && (quiet_now() || $urandom_range(99) >= 16);
        end
    end

    task automatic add_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             bit fin, bit drain = 1'b0);
        stim_t s;
        s.pt.pos_x       = x;
        s.pt.pos_y       = y;
        s.pt.last        = fin;
        s.drain_first    = drain;
        pending_pts.insert(pending_pts.size(), s);
    endtask

    // one well-formed run; tight clusters or full-range points
    task automatic add_random_run(int n);
        logic signed [CW-1:0] bx, by;
        bit                   wide;
        wide = $urandom_range(2) == 0;
        bx   = CW'($urandom);
        by   = CW'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (wide)
                add_point(CW'($urandom), CW'($urandom), i == n - 1);
            else
                add_point(bx + $signed(12'($urandom)), by + $signed(12'($urandom)),
                          i == n - 1);
        end
    endtask

    initial
    begin
        int queued;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        clear_run_state();

        // extremes and corners
        add_point(C_MAX, C_MAX, 1'b1);
        add_point(C_MIN, C_MIN, 1'b1);
        add_point('0, '0, 1'b1);
        add_point(C_MAX, C_MIN, 1'b0);
        add_point(C_MIN, C_MAX, 1'b0);
        add_point('0, '0, 1'b0);
        add_point(-24'sd1, 24'sd1, 1'b1);
        add_point(C_MIN, C_MIN, 1'b0);
        add_point(C_MIN, C_MIN, 1'b0);
        add_point(C_MAX, C_MAX, 1'b0);
        add_point(C_MAX, C_MAX, 1'b1);
        add_point(-24'sd3, -24'sd5, 1'b0);
        add_point(24'sd2, 24'sd1, 1'b0);
        add_point(24'sd256, -24'sd256, 1'b1);

        queued = 0;
        while (queued < 450)
        begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
            add_random_run(n);
            queued += n;
        end

        // sender waits for every result before this run
        add_point(24'sd100, 24'sd200, 1'b0, 1'b1);
        add_random_run(5);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pts.size() > 0 || in_ch.valid)
            @(posedge clk);
        while (stats_due.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
